// ----- rtl/i2c_master_bit_engine_assert.svh -----
// Assertion helpers; clock and reset are the names in scope at the use site.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define I2C_MBE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2c_mbe assertion failed");

// Next-cycle implication.
`define I2C_MBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2c_mbe assertion failed");

`endif

// ----- rtl/i2c_mbe_pkg.sv -----
`timescale 1ns / 1ps
package i2c_mbe_pkg;

   localparam int HP_WIDTH         = 16;
   localparam int BYTE_WIDTH       = 8;
   localparam int OP_WIDTH         = 3;
   localparam int CMD_QUEUE_DEPTH  = 2;
   localparam int RSP_QUEUE_DEPTH  = 2;

   localparam logic [HP_WIDTH-1:0] HALF_PERIOD_RESET = 16'd5;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_SACK  = 3'd4,
      OP_SNAK  = 3'd5,
      OP_RACK  = 3'd6
   } op_type;

   typedef struct packed {
      logic                  cmd_valid;
      logic                  cmd_legal;
      logic [OP_WIDTH-1:0]   opcode;
      logic [BYTE_WIDTH-1:0] tx_byte;
      logic                  sda_in;
   } cmd_beat_type;

   typedef struct packed {
      logic                  scl_out;
      logic                  sda_out;
      logic                  busy_res;
      logic                  done_res;
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  ack_bit;
      logic                  cmd_rejected;
   } rsp_beat_type;

endpackage

// ----- rtl/i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps
// channel   handshake               payload
// req       push / full             req_cmd_valid req_opcode req_tx_byte req_sda_in
// rsp       empty / pop             rsp_scl_out rsp_sda_out rsp_busy_res rsp_done_res
//                                   rsp_rx_byte rsp_ack_bit rsp_cmd_rejected
// csr       csr_valid / csr_ready   csr_half_period_ticks
//
// One tick beat accepted per cycle while full is low; its result beat passes through the
// command queue and the engine into the result queue, and can be popped once it is there.
// The engine state updates once per beat; it stalls only when the result queue
// is full, and full rises only when the command queue backs up behind it.
// Synchronous reset: pins released, half period 5, both queues empty. csr_ready is
// always high.
module i2c_master_bit_engine #(
   parameter int CMD_DEPTH = i2c_mbe_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = i2c_mbe_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_cmd_valid,
   input  logic [i2c_mbe_pkg::OP_WIDTH-1:0]   req_opcode,
   input  logic [i2c_mbe_pkg::BYTE_WIDTH-1:0] req_tx_byte,
   input  logic                               req_sda_in,
   output logic                               empty,
   input  logic                               pop,
   output logic                               rsp_scl_out,
   output logic                               rsp_sda_out,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic [i2c_mbe_pkg::BYTE_WIDTH-1:0] rsp_rx_byte,
   output logic                               rsp_ack_bit,
   output logic                               rsp_cmd_rejected,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [i2c_mbe_pkg::HP_WIDTH-1:0]   csr_half_period_ticks
);
   import i2c_mbe_pkg::*;

   cmd_beat_type cmd_beat;
   rsp_beat_type rsp_beat;
   logic         cmd_empty;
   logic         cmd_pop;

   i2c_mbe_front #(
      .DEPTH (CMD_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_cmd_valid (req_cmd_valid),
      .req_opcode    (req_opcode),
      .req_tx_byte   (req_tx_byte),
      .req_sda_in    (req_sda_in),
      .cmd_pop       (cmd_pop),
      .cmd_empty     (cmd_empty),
      .cmd_beat      (cmd_beat)
   );

   i2c_mbe_back #(
      .DEPTH (RSP_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_half_period_ticks (csr_half_period_ticks),
      .cmd_empty             (cmd_empty),
      .cmd_pop               (cmd_pop),
      .cmd_beat              (cmd_beat),
      .pop                   (pop),
      .empty                 (empty),
      .rsp_beat              (rsp_beat)
   );

   assign rsp_scl_out      = rsp_beat.scl_out;
   assign rsp_sda_out      = rsp_beat.sda_out;
   assign rsp_busy_res     = rsp_beat.busy_res;
   assign rsp_done_res     = rsp_beat.done_res;
   assign rsp_rx_byte      = rsp_beat.rx_byte;
   assign rsp_ack_bit      = rsp_beat.ack_bit;
   assign rsp_cmd_rejected = rsp_beat.cmd_rejected;

endmodule

// ----- rtl/i2c_mbe_queue.sv -----
`timescale 1ns / 1ps
module i2c_mbe_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/i2c_mbe_front.sv -----
`timescale 1ns / 1ps
module i2c_mbe_front #(
   parameter int DEPTH = i2c_mbe_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_cmd_valid,
   input  logic [i2c_mbe_pkg::OP_WIDTH-1:0]   req_opcode,
   input  logic [i2c_mbe_pkg::BYTE_WIDTH-1:0] req_tx_byte,
   input  logic                               req_sda_in,
   input  logic                               cmd_pop,
   output logic                               cmd_empty,
   output i2c_mbe_pkg::cmd_beat_type          cmd_beat
);
   import i2c_mbe_pkg::*;

   localparam int BEAT_W = $bits(cmd_beat_type);

   cmd_beat_type      beat_in;
   logic [BEAT_W-1:0] rd_data;

   always_comb begin
      beat_in.cmd_valid = req_cmd_valid;
      beat_in.cmd_legal = (req_opcode <= OP_RACK);
      beat_in.opcode    = req_opcode;
      beat_in.tx_byte   = req_tx_byte;
      beat_in.sda_in    = req_sda_in;
   end

   assign cmd_beat = cmd_beat_type'(rd_data);

   i2c_mbe_queue #(
      .WIDTH (BEAT_W),
      .DEPTH (DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .wr_data (BEAT_W'(beat_in)),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/i2c_mbe_back.sv -----
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_assert.svh"
module i2c_mbe_back #(
   parameter int DEPTH = i2c_mbe_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [i2c_mbe_pkg::HP_WIDTH-1:0] csr_half_period_ticks,
   input  logic                             cmd_empty,
   output logic                             cmd_pop,
   input  i2c_mbe_pkg::cmd_beat_type        cmd_beat,
   input  logic                             pop,
   output logic                             empty,
   output i2c_mbe_pkg::rsp_beat_type        rsp_beat
);
   import i2c_mbe_pkg::*;

   localparam int                    BEAT_W     = $bits(rsp_beat_type);
   localparam logic [1:0]            PH_FIRST   = 2'd0;
   localparam logic [1:0]            PH_SECOND  = 2'd1;
   localparam logic [3:0]            BITS_BYTE  = 4'd8;

   typedef struct packed {
      logic                  scl;
      logic                  sda;
      logic [BYTE_WIDTH-1:0] shift;
   } pins_type;

   function automatic logic [1:0] phases_per_bit(input op_type op);
      return (op == OP_WRITE || op == OP_RACK) ? 2'd3 : 2'd2;
   endfunction

   function automatic logic [3:0] bits_of(input op_type op);
      return (op == OP_WRITE || op == OP_READ) ? BITS_BYTE : 4'd1;
   endfunction

   function automatic pins_type enter_phase(input op_type op, input logic [1:0] ph,
                                            input pins_type cur);
      pins_type p;
      p = cur;
      unique case (op)
         OP_START: begin
            if (ph == PH_FIRST) begin
               p.sda = 1'b1;
               p.scl = 1'b1;
            end else begin
               p.sda = 1'b0;
            end
         end
         OP_STOP: begin
            if (ph == PH_FIRST) begin
               p.sda = 1'b0;
               p.scl = 1'b1;
            end else begin
               p.sda = 1'b1;
            end
         end
         OP_WRITE: begin
            if (ph == PH_FIRST) begin
               p.sda   = cur.shift[BYTE_WIDTH-1];
               p.shift = {cur.shift[BYTE_WIDTH-2:0], 1'b0};
            end else if (ph == PH_SECOND) begin
               p.scl = 1'b1;
            end else begin
               p.scl = 1'b0;
            end
         end
         OP_READ: begin
            if (ph == PH_FIRST) begin
               p.sda = 1'b1;
               p.scl = 1'b1;
            end else begin
               p.scl = 1'b0;
            end
         end
         OP_SACK, OP_SNAK: begin
            if (ph == PH_FIRST) begin
               p.sda = (op == OP_SNAK);
               p.scl = 1'b1;
            end else begin
               p.scl = 1'b0;
            end
         end
         default: begin
            // receive ack
            if (ph == PH_FIRST) begin
               p.sda = 1'b1;
            end else if (ph == PH_SECOND) begin
               p.scl = 1'b1;
            end else begin
               p.scl = 1'b0;
            end
         end
      endcase
      return p;
   endfunction

   logic [HP_WIDTH-1:0]   half_period_ff;
   op_type                active_op_ff, active_op_in;
   logic                  running_ff, running_in;
   logic [HP_WIDTH-1:0]   tick_count_ff, tick_count_in;
   logic [1:0]            phase_index_ff, phase_index_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [BYTE_WIDTH-1:0] shift_reg_ff, shift_reg_in;
   logic                  scl_level_ff, scl_level_in;
   logic                  sda_level_ff, sda_level_in;
   logic                  ack_reg_ff, ack_reg_in;
   logic [BYTE_WIDTH-1:0] rx_hold_ff, rx_hold_in;

   logic                  fire, rsp_full;
   logic                  done, rejected;
   logic [HP_WIDTH-1:0]   period;
   logic [BYTE_WIDTH-1:0] shift_mid;
   logic [1:0]            ph_next;
   logic [3:0]            bc_next;
   logic                  wrapped;
   op_type                new_op;
   pins_type              pins_cur, pins_nxt;
   rsp_beat_type          rsp_in;
   logic [BEAT_W-1:0]     rsp_rd;

   assign csr_ready = 1'b1;
   assign fire      = !cmd_empty && !rsp_full;
   assign cmd_pop   = fire;
   assign period    = (half_period_ff == '0) ? HP_WIDTH'(1) : half_period_ff;
   assign new_op    = op_type'(cmd_beat.opcode);

   always_comb begin
      active_op_in   = active_op_ff;
      running_in     = running_ff;
      tick_count_in  = tick_count_ff;
      phase_index_in = phase_index_ff;
      bit_count_in   = bit_count_ff;
      shift_reg_in   = shift_reg_ff;
      scl_level_in   = scl_level_ff;
      sda_level_in   = sda_level_ff;
      ack_reg_in     = ack_reg_ff;
      rx_hold_in     = rx_hold_ff;
      done           = 1'b0;
      rejected       = 1'b0;
      shift_mid      = shift_reg_ff;
      ph_next        = phase_index_ff + 2'd1;
      bc_next        = bit_count_ff;
      wrapped        = 1'b0;
      pins_cur       = '{scl: scl_level_ff, sda: sda_level_ff, shift: shift_reg_ff};
      pins_nxt       = pins_cur;

      if (running_ff) begin
         rejected = cmd_beat.cmd_valid;
         if (tick_count_ff >= period) begin
            if (active_op_ff == OP_READ && phase_index_ff == PH_FIRST) begin
               shift_mid = {shift_reg_ff[BYTE_WIDTH-2:0], cmd_beat.sda_in};
            end
            if (active_op_ff == OP_RACK && phase_index_ff == PH_SECOND) begin
               ack_reg_in = cmd_beat.sda_in;
            end
            if (ph_next >= phases_per_bit(active_op_ff)) begin
               ph_next = PH_FIRST;
               bc_next = bit_count_ff + 4'd1;
               wrapped = 1'b1;
            end
            if (wrapped && bc_next >= bits_of(active_op_ff)) begin
               if (active_op_ff == OP_START) begin
                  scl_level_in = 1'b0;
               end
               if (active_op_ff == OP_READ) begin
                  rx_hold_in = shift_mid;
               end
               shift_reg_in   = shift_mid;
               running_in     = 1'b0;
               phase_index_in = PH_FIRST;
               bit_count_in   = '0;
               tick_count_in  = '0;
               done           = 1'b1;
            end else begin
               pins_cur.shift = shift_mid;
               pins_nxt       = enter_phase(active_op_ff, ph_next, pins_cur);
               scl_level_in   = pins_nxt.scl;
               sda_level_in   = pins_nxt.sda;
               shift_reg_in   = pins_nxt.shift;
               phase_index_in = ph_next;
               bit_count_in   = bc_next;
               tick_count_in  = HP_WIDTH'(1);
            end
         end else begin
            tick_count_in = tick_count_ff + HP_WIDTH'(1);
         end
      end else if (cmd_beat.cmd_valid && cmd_beat.cmd_legal) begin
         if (new_op == OP_WRITE) begin
            pins_cur.shift = cmd_beat.tx_byte;
         end else if (new_op == OP_READ) begin
            pins_cur.shift = '0;
         end
         pins_nxt       = enter_phase(new_op, PH_FIRST, pins_cur);
         active_op_in   = new_op;
         running_in     = 1'b1;
         phase_index_in = PH_FIRST;
         bit_count_in   = '0;
         tick_count_in  = HP_WIDTH'(1);
         scl_level_in   = pins_nxt.scl;
         sda_level_in   = pins_nxt.sda;
         shift_reg_in   = pins_nxt.shift;
      end

      rsp_in.scl_out      = scl_level_in;
      rsp_in.sda_out      = sda_level_in;
      rsp_in.busy_res     = running_in;
      rsp_in.done_res     = done;
      rsp_in.rx_byte      = rx_hold_in;
      rsp_in.ack_bit      = ack_reg_in;
      rsp_in.cmd_rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         active_op_ff   <= OP_START;
         running_ff     <= 1'b0;
         tick_count_ff  <= '0;
         phase_index_ff <= PH_FIRST;
         bit_count_ff   <= '0;
         shift_reg_ff   <= '0;
         scl_level_ff   <= 1'b1;
         sda_level_ff   <= 1'b1;
         ack_reg_ff     <= 1'b1;
         rx_hold_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_half_period_ticks;
         end
         if (fire) begin
            active_op_ff   <= active_op_in;
            running_ff     <= running_in;
            tick_count_ff  <= tick_count_in;
            phase_index_ff <= phase_index_in;
            bit_count_ff   <= bit_count_in;
            shift_reg_ff   <= shift_reg_in;
            scl_level_ff   <= scl_level_in;
            sda_level_ff   <= sda_level_in;
            ack_reg_ff     <= ack_reg_in;
            rx_hold_ff     <= rx_hold_in;
         end
      end
   end

   assign rsp_beat = rsp_beat_type'(rsp_rd);

   i2c_mbe_queue #(
      .WIDTH (BEAT_W),
      .DEPTH (DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fire),
      .full    (rsp_full),
      .wr_data (BEAT_W'(rsp_in)),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_rd)
   );

   `I2C_MBE_ASSERT_NOW(a_idle_tick_clear, !running_ff, tick_count_ff == '0)
   `I2C_MBE_ASSERT_NOW(a_busy_tick_set, running_ff, tick_count_ff != '0)
   `I2C_MBE_ASSERT_NOW(a_bits_range, 1'b1, bit_count_ff <= BITS_BYTE)
   `I2C_MBE_ASSERT_NOW(a_done_from_busy, fire && done, running_ff && !running_in)
   `I2C_MBE_ASSERT_NEXT(a_beat_stored, fire, !empty)

endmodule

// ----- verif/tb_i2c_master_bit_engine.sv -----
`timescale 1ns / 1ps
module tb_i2c_master_bit_engine;
   import i2c_mbe_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 3'd7;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_HP [NUM_PHASES] = '{1, 2, 0, 3, 65535, 1, 4, 2};
   localparam int PHASE_TICKS [NUM_PHASES] = '{200, 200, 180, 180, 60, 200, 200, 180};

   typedef struct packed {
      logic                  cmd_valid;
      logic [OP_WIDTH-1:0]   opcode;
      logic [BYTE_WIDTH-1:0] tx_byte;
      logic                  sda_in;
   } tick_type;

   typedef enum logic [1:0] {
      ROW_ONCE,   // one beat
      ROW_DRAIN,  // beat, then idle ticks until the command is done
      ROW_LAST,   // idle ticks until the running command ends next tick, then beat
      ROW_CFG     // write half period = tx_byte while idle
   } row_mode_type;

   typedef struct packed {
      tick_type     beat;
      row_mode_type mode;
      logic         typed;
      rsp_beat_type want;
   } step_row_type;

   localparam rsp_beat_type RSP_RESET = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
      done_res: 1'b0, rx_byte: 8'h00, ack_bit: 1'b1, cmd_rejected: 1'b0};
   localparam rsp_beat_type RSP_STARTED = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
      done_res: 1'b0, rx_byte: 8'h00, ack_bit: 1'b1, cmd_rejected: 1'b0};
   localparam rsp_beat_type RSP_BUSY_REJ = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
      done_res: 1'b0, rx_byte: 8'h00, ack_bit: 1'b1, cmd_rejected: 1'b1};

   localparam int NUM_ROWS = 19;
   localparam step_row_type DIR_ROWS [NUM_ROWS] = '{
      '{'{1'b0, OP_START, 8'h00, 1'b1}, ROW_ONCE,  1'b1, RSP_RESET},
      '{'{1'b1, OP_UNUSED, 8'hFF, 1'b1}, ROW_ONCE, 1'b1, RSP_RESET},
      '{'{1'b1, OP_START, 8'h00, 1'b1}, ROW_ONCE,  1'b1, RSP_STARTED},
      '{'{1'b1, OP_STOP,  8'h00, 1'b0}, ROW_ONCE,  1'b1, RSP_BUSY_REJ},
      '{'{1'b1, OP_WRITE, 8'h5A, 1'b0}, ROW_LAST,  1'b0, RSP_RESET},
      '{'{1'b0, OP_START, 8'h00, 1'b0}, ROW_CFG,   1'b0, RSP_RESET},
      '{'{1'b1, OP_WRITE, 8'hFF, 1'b0}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_WRITE, 8'h00, 1'b1}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_WRITE, 8'hA5, 1'b0}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_RACK,  8'h00, 1'b0}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_RACK,  8'h00, 1'b1}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_READ,  8'h00, 1'b1}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_READ,  8'h00, 1'b0}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_SACK,  8'h00, 1'b1}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_SNAK,  8'h00, 1'b0}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_START, 8'h00, 1'b1}, ROW_DRAIN, 1'b0, RSP_RESET},
      '{'{1'b1, OP_READ,  8'h00, 1'b1}, ROW_ONCE,  1'b0, RSP_RESET},
      '{'{1'b1, OP_SACK,  8'h00, 1'b1}, ROW_LAST,  1'b0, RSP_RESET},
      '{'{1'b1, OP_STOP,  8'h00, 1'b1}, ROW_DRAIN, 1'b0, RSP_RESET}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_cmd_valid;
   logic [OP_WIDTH-1:0]   req_opcode;
   logic [BYTE_WIDTH-1:0] req_tx_byte;
   logic                  req_sda_in;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  rsp_scl_out;
   logic                  rsp_sda_out;
   logic                  rsp_busy_res;
   logic                  rsp_done_res;
   logic [BYTE_WIDTH-1:0] rsp_rx_byte;
   logic                  rsp_ack_bit;
   logic                  rsp_cmd_rejected;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [HP_WIDTH-1:0]   csr_half_period_ticks;

   i2c_master_bit_engine uut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_cmd_valid         (req_cmd_valid),
      .req_opcode            (req_opcode),
      .req_tx_byte           (req_tx_byte),
      .req_sda_in            (req_sda_in),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_scl_out           (rsp_scl_out),
      .rsp_sda_out           (rsp_sda_out),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_rx_byte           (rsp_rx_byte),
      .rsp_ack_bit           (rsp_ack_bit),
      .rsp_cmd_rejected      (rsp_cmd_rejected),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_half_period_ticks (csr_half_period_ticks)
   );

   always #4 clock = ~clock;

   // engine model state
   logic [HP_WIDTH-1:0]   hp_cfg;
   op_type                eng_op;
   logic                  eng_running;
   logic [15:0]           eng_ticks;
   logic [1:0]            eng_phase;
   logic [3:0]            eng_bits;
   logic [BYTE_WIDTH-1:0] eng_shift;
   logic                  scl_lvl;
   logic                  sda_lvl;
   logic                  ack_lvl;
   logic [BYTE_WIDTH-1:0] rx_hold;

   rsp_beat_type pending_rsp_q [$];
   int           mismatch_count = 0;
   logic         typed_pending = 1'b0;
   rsp_beat_type typed_want = RSP_RESET;
   int           burst_left = 0;
   int           gap_left = 0;
   logic [15:0]  stall_pat = '0;
   logic [5:0]   stall_cnt = '0;

   function automatic void reset_engine_model();
      hp_cfg      = HALF_PERIOD_RESET;
      eng_op      = OP_START;
      eng_running = 1'b0;
      eng_ticks   = '0;
      eng_phase   = '0;
      eng_bits    = '0;
      eng_shift   = '0;
      scl_lvl     = 1'b1;
      sda_lvl     = 1'b1;
      ack_lvl     = 1'b1;
      rx_hold     = '0;
   endfunction

   function automatic int period_ticks();
      return (hp_cfg == 0) ? 1 : int'(hp_cfg);
   endfunction

   function automatic int phase_count(op_type op);
      return (op == OP_WRITE || op == OP_RACK) ? 3 : 2;
   endfunction

   function automatic int bit_total(op_type op);
      return (op == OP_WRITE || op == OP_READ) ? 8 : 1;
   endfunction

   function automatic void enter_phase(logic [1:0] ph);
      case (eng_op)
         OP_START: begin
            if (ph == 0) begin
               sda_lvl = 1'b1;
               scl_lvl = 1'b1;
            end else begin
               sda_lvl = 1'b0;
            end
         end
         OP_STOP: begin
            if (ph == 0) begin
               sda_lvl = 1'b0;
               scl_lvl = 1'b1;
            end else begin
               sda_lvl = 1'b1;
            end
         end
         OP_WRITE: begin
            if (ph == 0) begin
               sda_lvl   = eng_shift[7];
               eng_shift = {eng_shift[6:0], 1'b0};
            end else begin
               scl_lvl = (ph == 1);
            end
         end
         OP_READ: begin
            if (ph == 0) begin
               sda_lvl = 1'b1;
               scl_lvl = 1'b1;
            end else begin
               scl_lvl = 1'b0;
            end
         end
         OP_SACK, OP_SNAK: begin
            if (ph == 0) begin
               sda_lvl = (eng_op == OP_SNAK);
               scl_lvl = 1'b1;
            end else begin
               scl_lvl = 1'b0;
            end
         end
         default: begin
            if (ph == 0) sda_lvl = 1'b1;
            else scl_lvl = (ph == 1);
         end
      endcase
   endfunction

   // returns 1 when the command finishes
   function automatic logic close_phase(logic sda);
      if (eng_op == OP_READ && eng_phase == 0) eng_shift = {eng_shift[6:0], sda};
      if (eng_op == OP_RACK && eng_phase == 1) ack_lvl = sda;
      eng_phase++;
      if (eng_phase >= phase_count(eng_op)) begin
         eng_phase = '0;
         eng_bits++;
         if (eng_bits >= bit_total(eng_op)) begin
            if (eng_op == OP_START) scl_lvl = 1'b0;
            if (eng_op == OP_READ) rx_hold = eng_shift;
            eng_running = 1'b0;
            eng_bits    = '0;
            eng_ticks   = '0;
            return 1'b1;
         end
      end
      enter_phase(eng_phase);
      eng_ticks = 16'd1;
      return 1'b0;
   endfunction

   function automatic rsp_beat_type predict_tick(tick_type t);
      rsp_beat_type r;
      logic         done;
      logic         rej;
      done = 1'b0;
      rej  = 1'b0;
      if (eng_running) begin
         rej = t.cmd_valid;
         if (int'(eng_ticks) >= period_ticks()) done = close_phase(t.sda_in);
         else eng_ticks++;
      end else if (t.cmd_valid && t.opcode != OP_UNUSED) begin
         eng_op      = op_type'(t.opcode);
         eng_running = 1'b1;
         eng_phase   = '0;
         eng_bits    = '0;
         eng_ticks   = 16'd1;
         if (eng_op == OP_WRITE) eng_shift = t.tx_byte;
         else if (eng_op == OP_READ) eng_shift = '0;
         enter_phase(2'd0);
      end
      r.scl_out      = scl_lvl;
      r.sda_out      = sda_lvl;
      r.busy_res     = eng_running;
      r.done_res     = done;
      r.rx_byte      = rx_hold;
      r.ack_bit      = ack_lvl;
      r.cmd_rejected = rej;
      return r;
   endfunction

   function automatic logic ends_next_tick();
      return eng_running && int'(eng_ticks) >= period_ticks()
         && eng_phase == phase_count(eng_op) - 1 && eng_bits == bit_total(eng_op) - 1;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // scoreboard: predictor on input beats, compare on result beats
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) hp_cfg = csr_half_period_ticks;
         if (push && !full) begin
            want = predict_tick('{req_cmd_valid, req_opcode, req_tx_byte, req_sda_in});
            if (typed_pending) want = typed_want;
            pending_rsp_q.push_back(want);
         end
         if (pop && !empty) begin
            if (pending_rsp_q.size() == 0) begin
               $error("result beat with nothing expected");
               mismatch_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("scl_out", want.scl_out, rsp_scl_out);
               check_field("sda_out", want.sda_out, rsp_sda_out);
               check_field("busy_res", want.busy_res, rsp_busy_res);
               check_field("done_res", want.done_res, rsp_done_res);
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("ack_bit", want.ack_bit, rsp_ack_bit);
               check_field("cmd_rejected", want.cmd_rejected, rsp_cmd_rejected);
            end
         end
      end
   end

   // receiver stall pattern, new one each time stall_cnt wraps to zero
   always @(negedge clock) begin
      if (stall_cnt == 0) begin
         if ($urandom_range(0, 3) == 0) stall_pat = '0;
         else stall_pat = 16'($urandom) & 16'hFFFE;
      end
      pop <= !stall_pat[stall_cnt[3:0]];
      stall_cnt = stall_cnt + 1'b1;
   end

   task automatic send_tick(input tick_type t, input logic typed, input rsp_beat_type want);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      while (gap_left > 0) begin
         push <= 1'b0;
         @(negedge clock);
         gap_left--;
      end
      typed_pending = typed;
      typed_want    = want;
      push          <= 1'b1;
      req_cmd_valid <= t.cmd_valid;
      req_opcode    <= t.opcode;
      req_tx_byte   <= t.tx_byte;
      req_sda_in    <= t.sda_in;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      typed_pending = 1'b0;
      burst_left--;
   endtask

   task automatic idle_tick(input logic sda);
      send_tick('{1'b0, OP_START, 8'h00, sda}, 1'b0, RSP_RESET);
   endtask

   task automatic write_half_period(input logic [HP_WIDTH-1:0] value);
      push <= 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid             <= 1'b1;
      csr_half_period_ticks <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic tick_type random_tick();
      tick_type t;
      int       pick;
      if (!eng_running) t.cmd_valid = ($urandom_range(0, 1) == 0);
      else if (ends_next_tick()) t.cmd_valid = ($urandom_range(0, 1) == 0);
      else t.cmd_valid = ($urandom_range(0, 24) == 0);
      if (eng_running || $urandom_range(0, 15) == 0) t.opcode = OP_WIDTH'($urandom_range(0, 7));
      else t.opcode = OP_WIDTH'($urandom_range(0, 6));
      pick = $urandom_range(0, 7);
      if (pick == 0) t.tx_byte = 8'h00;
      else if (pick == 1) t.tx_byte = 8'hFF;
      else t.tx_byte = 8'($urandom);
      t.sda_in = 1'($urandom_range(0, 1));
      return t;
   endfunction

   initial begin
      step_row_type row;
      reset_engine_model();
      reset                 = 1'b1;
      push                  = 1'b0;
      req_cmd_valid         = 1'b0;
      req_opcode            = OP_START;
      req_tx_byte           = '0;
      req_sda_in            = 1'b1;
      csr_valid             = 1'b0;
      csr_half_period_ticks = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIR_ROWS[i];
         case (row.mode)
            ROW_CFG: begin
               write_half_period(HP_WIDTH'(row.beat.tx_byte));
            end
            ROW_LAST: begin
               while (eng_running && !ends_next_tick()) idle_tick(row.beat.sda_in);
               send_tick(row.beat, row.typed, row.want);
            end
            default: begin
               send_tick(row.beat, row.typed, row.want);
               if (row.mode == ROW_DRAIN) begin
                  while (eng_running) idle_tick(row.beat.sda_in);
               end
            end
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_half_period(HP_WIDTH'(PHASE_HP[p]));
         repeat (PHASE_TICKS[p]) send_tick(random_tick(), 1'b0, RSP_RESET);
      end

      push <= 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/i2c_mbe_pkg.sv
rtl/i2c_mbe_queue.sv
rtl/i2c_mbe_front.sv
rtl/i2c_mbe_back.sv
rtl/i2c_master_bit_engine.sv
verif/tb_i2c_master_bit_engine.sv
